[hw/rtl/pnrm_pkg.sv]
// Shared types and constants for the per-node receive mailbox.
// Holds the operation and status codes, the field widths and the command record.
// It has no dependencies and is compiled first.
`default_nettype none

package pnrm_pkg;

  localparam int unsigned OP_W      = 2;
  localparam int unsigned NODE_W    = 8;
  localparam int unsigned PAYLOAD_W = 64;
  localparam int unsigned COUNT_W   = 4;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned CFG_W     = 5;

  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_PTR_W = 1;
  localparam int unsigned FIFO_CNT_W = 2;

  localparam logic [OP_W-1:0] OP_STORE = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

  typedef enum logic [1:0] {
    KIND_STORE,
    KIND_READ,
    KIND_QUERY,
    KIND_RANGE
  } kind_e;

  typedef struct packed {
    kind_e                kind;
    logic [NODE_W-1:0]    queue;
    logic [PAYLOAD_W-1:0] payload;
  } cmd_t;

endpackage

`default_nettype wire

[hw/rtl/pnrm_front.sv]
// Front end of the mailbox: holds the node-count register and classifies items.
// Depends on pnrm_pkg; feeds commands into pnrm_cmd_fifo.
`default_nettype none

module pnrm_front import pnrm_pkg::*; #(
  parameter int unsigned NODE_QUEUES = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [OP_W-1:0]      operation_i,
  input  wire logic [NODE_W-1:0]    node_number_i,
  input  wire logic [PAYLOAD_W-1:0] frame_payload_i,
  output logic                      clear_o,
  output logic                      push_valid_o,
  input  wire logic                 push_ready_i,
  output cmd_t                      push_data_o
);

  logic [CFG_W-1:0] nodes_q;
  logic [CFG_W-1:0] nodes_d;
  logic             out_of_range;

  assign cfg_ready_o = 1'b1;
  assign clear_o     = cfg_valid_i;
  assign nodes_d     = cfg_valid_i ? cfg_data_i : nodes_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nodes_q <= '0;
    end else begin
      nodes_q <= nodes_d;
    end
  end

  assign out_of_range = (node_number_i == '0)
                     || (node_number_i > {{(NODE_W-CFG_W){1'b0}}, nodes_q})
                     || (node_number_i > NODE_W'(NODE_QUEUES));

  always_comb begin
    push_data_o.queue   = node_number_i - NODE_W'(1);
    push_data_o.payload = frame_payload_i;
    if (out_of_range) begin
      push_data_o.kind = KIND_RANGE;
    end else begin
      case (operation_i)
        OP_STORE: push_data_o.kind = KIND_STORE;
        OP_READ:  push_data_o.kind = KIND_READ;
        default:  push_data_o.kind = KIND_QUERY;
      endcase
    end
  end

  assign push_valid_o = in_valid_i;
  assign in_ready_o   = push_ready_i;

endmodule

`default_nettype wire

[hw/rtl/pnrm_cmd_fifo.sv]
// Two-entry command queue between the front end and the back end.
// Depends on pnrm_pkg for the command record and the queue sizing.
`default_nettype none

module pnrm_cmd_fifo import pnrm_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_valid_i,
  output logic      push_ready_o,
  input  cmd_t      push_data_i,
  output logic      pop_valid_o,
  input  wire logic pop_ready_i,
  output cmd_t      pop_data_o
);

  cmd_t                  mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0] cnt_q, cnt_d;
  logic                  push, pop;

  assign push_ready_o = (cnt_q != FIFO_CNT_W'(FIFO_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  assign wr_ptr_d = push ? wr_ptr_q + FIFO_PTR_W'(1) : wr_ptr_q;
  assign rd_ptr_d = pop ? rd_ptr_q + FIFO_PTR_W'(1) : rd_ptr_q;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + FIFO_CNT_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - FIFO_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/pnrm_back.sv]
// Back end of the mailbox: per-node ring state, payload memory and result register.
// Depends on pnrm_pkg; takes commands from pnrm_cmd_fifo.
`default_nettype none

module pnrm_back import pnrm_pkg::*; #(
  parameter int unsigned NODE_QUEUES = 16,
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  clear_i,
  input  wire logic                  pop_valid_i,
  output logic                       pop_ready_o,
  input  cmd_t                       pop_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [PAYLOAD_W-1:0]       read_payload_o,
  output logic [COUNT_W-1:0]         pending_count_o,
  output logic [STATUS_W-1:0]        status_o
);

  localparam int unsigned SLOT_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned QIDX_W = (NODE_QUEUES > 1) ? $clog2(NODE_QUEUES) : 1;
  localparam int unsigned SLOTS  = NODE_QUEUES * QUEUE_DEPTH;
  localparam int unsigned ADDR_W = $clog2(SLOTS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_DATA,
    S_OUT
  } state_e;

  typedef struct packed {
    logic [SLOT_W-1:0] wr;
    logic [SLOT_W-1:0] rd;
    logic [CNT_W-1:0]  cnt;
  } node_t;

  state_e                 state_q;
  cmd_t                   cmd_q;
  logic [NODE_QUEUES-1:0] vld_q;
  logic [PAYLOAD_W-1:0]   res_payload_q;
  logic [COUNT_W-1:0]     res_count_q;
  logic [STATUS_W-1:0]    res_status_q;

  node_t                  node_mem [NODE_QUEUES];
  node_t                  node_rd_q;
  logic [PAYLOAD_W-1:0]   pay_mem [SLOTS];
  logic [PAYLOAD_W-1:0]   pay_rd_q;

  logic [QIDX_W-1:0]      head_idx;
  logic [QIDX_W-1:0]      cur_idx;
  node_t                  cur;
  node_t                  node_wdata;
  logic                   node_we;
  logic                   pay_we;
  logic                   pay_re;
  logic [SLOT_W-1:0]      pay_slot;
  logic [ADDR_W-1:0]      pay_addr;
  logic [CNT_W-1:0]       new_cnt;
  logic [31:0]            new_cnt_ext;
  logic [STATUS_W-1:0]    new_status;
  logic                   take;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] n;
    n = (s == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : s + SLOT_W'(1);
    return n;
  endfunction

  assign pop_ready_o = (state_q == S_IDLE);
  assign take        = pop_valid_i && pop_ready_o;
  assign head_idx    = pop_data_i.queue[QIDX_W-1:0];
  assign cur_idx     = cmd_q.queue[QIDX_W-1:0];
  assign cur         = vld_q[cur_idx] ? node_rd_q : '0;
  assign pay_addr    = ADDR_W'(cur_idx) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(pay_slot);
  assign new_cnt_ext = 32'(new_cnt);

  always_comb begin
    node_we    = 1'b0;
    node_wdata = cur;
    pay_we     = 1'b0;
    pay_re     = 1'b0;
    pay_slot   = cur.wr;
    new_cnt    = cur.cnt;
    new_status = ST_OK;
    if (state_q == S_LOOK) begin
      case (cmd_q.kind)
        KIND_RANGE: begin
          new_cnt    = '0;
          new_status = ST_RANGE;
        end
        KIND_STORE: begin
          if (cur.cnt == CNT_W'(QUEUE_DEPTH)) begin
            new_status = ST_FULL;
          end else begin
            pay_we        = 1'b1;
            node_we       = 1'b1;
            node_wdata.wr = next_slot(cur.wr);
            new_cnt       = cur.cnt + CNT_W'(1);
          end
        end
        KIND_READ: begin
          pay_slot = cur.rd;
          if (cur.cnt == '0) begin
            new_status = ST_EMPTY;
          end else begin
            pay_re        = 1'b1;
            node_we       = 1'b1;
            node_wdata.rd = next_slot(cur.rd);
            new_cnt       = cur.cnt - CNT_W'(1);
          end
        end
        default: begin
          new_status = ST_OK;
        end
      endcase
      node_wdata.cnt = new_cnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      cmd_q         <= '0;
      vld_q         <= '0;
      res_payload_q <= '0;
      res_count_q   <= '0;
      res_status_q  <= ST_OK;
    end else begin
      if (clear_i) begin
        vld_q <= '0;
      end else if (node_we) begin
        vld_q[cur_idx] <= 1'b1;
      end
      case (state_q)
        S_IDLE: begin
          if (take) begin
            cmd_q   <= pop_data_i;
            state_q <= S_LOOK;
          end
        end
        S_LOOK: begin
          res_payload_q <= '0;
          res_count_q   <= new_cnt_ext[COUNT_W-1:0];
          res_status_q  <= new_status;
          state_q       <= pay_re ? S_DATA : S_OUT;
        end
        S_DATA: begin
          res_payload_q <= pay_rd_q;
          state_q       <= S_OUT;
        end
        S_OUT: begin
          if (out_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      node_rd_q <= node_mem[head_idx];
    end
    if (node_we) begin
      node_mem[cur_idx] <= node_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pay_we) begin
      pay_mem[pay_addr] <= cmd_q.payload;
    end
    if (pay_re) begin
      pay_rd_q <= pay_mem[pay_addr];
    end
  end

  assign out_valid_o     = (state_q == S_OUT);
  assign read_payload_o  = res_payload_q;
  assign pending_count_o = res_count_q;
  assign status_o        = res_status_q;

endmodule

`default_nettype wire

[hw/rtl/per_node_receive_mailbox.sv]
// Per-node receive mailbox: one ring queue of 8-byte payloads per sending node.
// An accepted item waits in the command FIFO; the back end then takes it through S_LOOK,
// and S_DATA for a successful read, to a registered result held in S_OUT until taken.
// It takes one command at a time through the node-state and payload memory read ports.
// Reset empties every queue and clears the node count; no clearing pass is needed.
// Instantiates pnrm_front, pnrm_cmd_fifo and pnrm_back; depends on pnrm_pkg.
`default_nettype none

module per_node_receive_mailbox import pnrm_pkg::*; #(
  parameter int unsigned NODE_QUEUES = 16,
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [OP_W-1:0]      operation_i,
  input  wire logic [NODE_W-1:0]    node_number_i,
  input  wire logic [PAYLOAD_W-1:0] frame_payload_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [PAYLOAD_W-1:0]      read_payload_o,
  output logic [COUNT_W-1:0]        pending_count_o,
  output logic [STATUS_W-1:0]       status_o
);

  localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(QUEUE_DEPTH);

  logic clear;
  logic push_valid, push_ready;
  logic pop_valid, pop_ready;
  cmd_t push_data, pop_data;

  pnrm_front #(
    .NODE_QUEUES(NODE_QUEUES)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .operation_i    (operation_i),
    .node_number_i  (node_number_i),
    .frame_payload_i(frame_payload_i),
    .clear_o        (clear),
    .push_valid_o   (push_valid),
    .push_ready_i   (push_ready),
    .push_data_o    (push_data)
  );

  pnrm_cmd_fifo u_cmd_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_data_i (push_data),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_data_o  (pop_data)
  );

  pnrm_back #(
    .NODE_QUEUES(NODE_QUEUES),
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .clear_i        (clear),
    .pop_valid_i    (pop_valid),
    .pop_ready_o    (pop_ready),
    .pop_data_i     (pop_data),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .read_payload_o (read_payload_o),
    .pending_count_o(pending_count_o),
    .status_o       (status_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_RANGE) |-> (read_payload_o == '0 && pending_count_o == '0))
    else $error("Out-of-range result carries a payload or a count.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_EMPTY) |-> (read_payload_o == '0 && pending_count_o == '0))
    else $error("Empty-queue read result carries a payload or a count.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_FULL) |-> (read_payload_o == '0 && pending_count_o == FULL_COUNT))
    else $error("Dropped frame reported with a wrong pending count.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_valid && pop_ready) |=> !out_valid_o)
    else $error("Result presented in the cycle after a command transfer.");

endmodule

`default_nettype wire

[verif/tb_top.sv]
// Self-checking testbench for the per-node receive mailbox. It drives store, read and
// query transfers and predicts every result from its own model of the per-node queues.
// Depends on pnrm_pkg and per_node_receive_mailbox from the RTL.
`default_nettype none

module tb_top import pnrm_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NODE_QUEUES = 16;
  localparam int unsigned QUEUE_DEPTH = 8;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int unsigned PHASE_ITEMS = 80;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned CYCLE_LIMIT = 1000000;

  typedef struct {
    logic [PAYLOAD_W-1:0] payload;
    logic [COUNT_W-1:0]   count;
    logic [STATUS_W-1:0]  status;
  } mbox_result_t;

  class mailbox_scoreboard;
    logic [PAYLOAD_W-1:0] slot_data [NODE_QUEUES][QUEUE_DEPTH];
    int unsigned wr_pos [NODE_QUEUES];
    int unsigned rd_pos [NODE_QUEUES];
    int unsigned fill [NODE_QUEUES];
    int unsigned node_limit;
    mbox_result_t due_q [$];
    int unsigned errors;

    function void set_node_count(int unsigned value);
      node_limit = value;
      foreach (fill[q]) begin
        wr_pos[q] = 0;
        rd_pos[q] = 0;
        fill[q] = 0;
      end
    endfunction

    function void note_item(logic [OP_W-1:0] op, logic [NODE_W-1:0] node,
                            logic [PAYLOAD_W-1:0] data);
      mbox_result_t res;
      int unsigned q;
      res.payload = '0;
      res.count = '0;
      res.status = ST_OK;
      if (node == 0 || node > node_limit || node > NODE_QUEUES) begin
        res.status = ST_RANGE;
      end else begin
        q = node - 1;
        if (op == OP_STORE) begin
          if (fill[q] >= QUEUE_DEPTH) begin
            res.status = ST_FULL;
          end else begin
            slot_data[q][wr_pos[q]] = data;
            wr_pos[q] = (wr_pos[q] + 1) % QUEUE_DEPTH;
            fill[q]++;
          end
        end else if (op == OP_READ) begin
          if (fill[q] == 0) begin
            res.status = ST_EMPTY;
          end else begin
            res.payload = slot_data[q][rd_pos[q]];
            rd_pos[q] = (rd_pos[q] + 1) % QUEUE_DEPTH;
            fill[q]--;
          end
        end
        res.count = fill[q][COUNT_W-1:0];
      end
      due_q.push_back(res);
    endfunction

    function void check_result(logic [PAYLOAD_W-1:0] payload, logic [COUNT_W-1:0] count,
                               logic [STATUS_W-1:0] status);
      mbox_result_t exp_res;
      if (due_q.size() == 0) begin
        $display("%0t: unexpected result transfer, payload %h count %0d status %0d",
                 $realtime, payload, count, status);
        errors++;
        return;
      end
      exp_res = due_q.pop_front();
      if (payload !== exp_res.payload) begin
        $display("%0t: read_payload expected %h actual %h", $realtime, exp_res.payload,
                 payload);
        errors++;
      end
      if (count !== exp_res.count) begin
        $display("%0t: pending_count expected %0d actual %0d", $realtime, exp_res.count,
                 count);
        errors++;
      end
      if (status !== exp_res.status) begin
        $display("%0t: status expected %0d actual %0d", $realtime, exp_res.status, status);
        errors++;
      end
    endfunction

    function int unsigned outstanding();
      return due_q.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [CFG_W-1:0] cfg_data_i;
  logic in_valid_i;
  logic in_ready_o;
  logic [OP_W-1:0] operation_i;
  logic [NODE_W-1:0] node_number_i;
  logic [PAYLOAD_W-1:0] frame_payload_i;
  logic out_valid_o;
  logic out_ready_i;
  logic [PAYLOAD_W-1:0] read_payload_o;
  logic [COUNT_W-1:0] pending_count_o;
  logic [STATUS_W-1:0] status_o;

  mailbox_scoreboard sb;
  bit hold_request;
  bit no_idle;

  per_node_receive_mailbox #(
    .NODE_QUEUES(NODE_QUEUES),
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .operation_i(operation_i),
    .node_number_i(node_number_i),
    .frame_payload_i(frame_payload_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .read_payload_o(read_payload_o),
    .pending_count_o(pending_count_o),
    .status_o(status_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic wait_drained();
    while (sb.outstanding() != 0) @(posedge clk_i);
  endtask

  task automatic send_item(logic [OP_W-1:0] op, logic [NODE_W-1:0] node,
                           logic [PAYLOAD_W-1:0] data);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= op;
    node_number_i <= node;
    frame_payload_i <= data;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_item(op, node, data);
  endtask

  task automatic write_node_count(logic [CFG_W-1:0] value);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_node_count(value);
  endtask

  task automatic run_random_phase(int unsigned node_count, int unsigned hold_at,
                                  int unsigned pause_at);
    int unsigned span;
    int unsigned focus;
    int unsigned store_pct;
    int unsigned r;
    logic [OP_W-1:0] op;
    logic [NODE_W-1:0] node;
    logic [PAYLOAD_W-1:0] data;
    span = (node_count > NODE_QUEUES) ? NODE_QUEUES : node_count;
    focus = (span < 4) ? span : 4;
    store_pct = 60;
    for (int unsigned i = 0; i < PHASE_ITEMS; i++) begin
      if (i % 16 == 0) store_pct = $urandom_range(0, 1) ? 75 : 30;
      if (i == hold_at) hold_request = 1'b1;
      if (i == pause_at) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        wait_drained();
      end
      r = $urandom_range(0, 99);
      if (r < 6) op = OP_QUERY;
      else if (r < 10) op = OP_UNUSED;
      else if ($urandom_range(0, 99) < store_pct) op = OP_STORE;
      else op = OP_READ;
      r = $urandom_range(0, 99);
      if (span > 0 && r < 60) begin
        node = NODE_W'($urandom_range(1, focus));
      end else if (span > 0 && r < 88) begin
        node = NODE_W'($urandom_range(1, span));
      end else begin
        case ($urandom_range(0, 3))
          0: node = 8'd0;
          1: node = 8'd255;
          2: node = NODE_W'($urandom_range(0, 255));
          default: node = NODE_W'($urandom_range(span + 1, 255));
        endcase
      end
      r = $urandom_range(0, 99);
      if (r < 4) data = '0;
      else if (r < 8) data = '1;
      else data = {$urandom(), $urandom()};
      send_item(op, node, data);
    end
  endtask

  initial begin
    int unsigned stall_left;
    out_ready_i <= 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o === 1'b1 && out_ready_i) begin
        sb.check_result(read_payload_o, pending_count_o, status_o);
      end
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    sb = new();
    hold_request = 1'b0;
    no_idle = 1'b0;
    rst_ni = 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_data_i <= '0;
    in_valid_i <= 1'b0;
    operation_i <= OP_STORE;
    node_number_i <= '0;
    frame_payload_i <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // No node owns a queue straight after reset.
    send_item(OP_STORE, 8'd1, 64'h0123_4567_89ab_cdef);
    send_item(OP_READ, 8'd0, '0);

    write_node_count(5'd16);
    send_item(OP_STORE, 8'd1, '0);
    send_item(OP_STORE, 8'd1, '1);
    send_item(OP_READ, 8'd1, '0);
    send_item(OP_READ, 8'd1, '0);
    send_item(OP_READ, 8'd1, '0);
    send_item(OP_QUERY, 8'd1, '1);
    send_item(OP_UNUSED, 8'd1, '0);
    for (int unsigned i = 0; i <= QUEUE_DEPTH; i++) begin
      send_item(OP_STORE, 8'd16, {$urandom(), $urandom()});
    end
    send_item(OP_READ, 8'd16, '0);
    send_item(OP_STORE, 8'd17, '1);
    send_item(OP_READ, 8'd255, '0);
    send_item(OP_QUERY, 8'd0, '0);

    // Node counts above the number of queues still stop at the last queue.
    write_node_count(5'd31);
    send_item(OP_STORE, 8'd16, 64'h8000_0000_0000_0001);
    send_item(OP_STORE, 8'd17, '1);
    send_item(OP_QUERY, 8'd31, '0);

    write_node_count(5'd16);
    run_random_phase(16, 10, PHASE_ITEMS);
    write_node_count(5'd5);
    run_random_phase(5, PHASE_ITEMS, PHASE_ITEMS);
    write_node_count(5'd1);
    run_random_phase(1, PHASE_ITEMS, 40);
    write_node_count(5'd31);
    run_random_phase(31, PHASE_ITEMS, PHASE_ITEMS);
    no_idle = 1'b1;
    write_node_count(5'd12);
    run_random_phase(12, PHASE_ITEMS, PHASE_ITEMS);
    no_idle = 1'b0;
    begin
      logic [CFG_W-1:0] any_count;
      any_count = CFG_W'($urandom_range(2, 15));
      write_node_count(any_count);
      run_random_phase(any_count, 50, PHASE_ITEMS);
    end
    write_node_count(5'd16);
    run_random_phase(16, PHASE_ITEMS, PHASE_ITEMS);

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait_drained();
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
